// ===== rtl/distinct_value_frequency_counter_macros.svh =====
// ----------------------------------------------------------------------------
// Distinct value frequency counter assertion macros
// Shared property wrappers for the checker of the frequency counter.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_VALUE_FREQUENCY_COUNTER_MACROS_SVH
`define DISTINCT_VALUE_FREQUENCY_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DVFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvfc check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DVFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvfc check failed");

`endif

// ===== rtl/dvfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Distinct value frequency counter package
// Shared types, command codes and controller interface structs.
// ----------------------------------------------------------------------------
package dvfc_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] entry_value;
        logic [31:0]        entry_count;
        logic               last_entry;
        logic               dropped_flag;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_run;
        logic rank;
        logic increment;
        logic append;
        logic emit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic empty;
        logic last;
    } ctrl_sts_t;

endpackage

// ===== rtl/dvfc_controller.sv =====
// ----------------------------------------------------------------------------
// Distinct value frequency counter controller
// Sequences table searches, appends and the descending report passes.
// ----------------------------------------------------------------------------
module dvfc_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 item_cmd,
    input  dvfc_pkg::ctrl_sts_t  sts,
    output dvfc_pkg::ctrl_cmd_t  cmd,
    output logic                 busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ADD    = 3'b010,
        S_REPORT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_clear = 1'b1;
                    if (item_cmd == dvfc_pkg::CMD_REPORT)
                    begin
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                cmd.scan_run = 1'b1;
                if (sts.hit)
                begin
                    cmd.increment = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (sts.scan_done)
                begin
                    cmd.append = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REPORT:
            begin
                cmd.scan_run = 1'b1;
                cmd.rank     = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.empty)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                        if (sts.last)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_clear = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/dvfc_datapath.sv =====
// ----------------------------------------------------------------------------
// Distinct value frequency counter datapath
// Value and count memories, one scan comparator, ranking and result register.
// ----------------------------------------------------------------------------
module dvfc_datapath #(
    parameter int TABLE_ENTRIES = dvfc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dvfc_pkg::in_item_t   item,
    input  dvfc_pkg::ctrl_cmd_t  cmd,
    output dvfc_pkg::ctrl_sts_t  sts,
    output logic                 result_valid,
    output dvfc_pkg::out_item_t  result
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [31:0] val_mem [TABLE_ENTRIES];
    logic [31:0] cnt_mem [TABLE_ENTRIES];

    logic [CW-1:0]      used_reg;
    logic               ovf_reg;
    logic [CW-1:0]      idx_reg;
    logic               cmp_vld_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic               found_reg;
    logic               bound_vld_reg;
    logic [CW-1:0]      emitted_reg;
    logic               result_valid_reg;
    logic signed [31:0] sample_reg;
    logic signed [31:0] best_val_reg;
    logic [31:0]        best_cnt_reg;
    logic signed [31:0] bound_reg;
    logic [31:0]        rd_val_reg;
    logic [31:0]        rd_cnt_reg;
    dvfc_pkg::out_item_t result_reg;

    logic          table_full;
    logic          candidate;
    logic          wr_val_en;
    logic          wr_cnt_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_cnt;

    assign table_full = (used_reg == CW'(TABLE_ENTRIES));

    assign sts.hit       = cmp_vld_reg && (rd_val_reg == sample_reg);
    assign sts.scan_done = !cmp_vld_reg && (idx_reg == used_reg);
    assign sts.empty     = (used_reg == '0);
    assign sts.last      = (emitted_reg == (used_reg - CW'(1)));

    assign candidate = cmp_vld_reg
                    && (!bound_vld_reg || ($signed(rd_val_reg) < bound_reg))
                    && (!found_reg || ($signed(rd_val_reg) > best_val_reg));

    always_comb
    begin
        wr_val_en = 1'b0;
        wr_cnt_en = 1'b0;
        wr_addr   = cmp_idx_reg;
        wr_cnt    = (rd_cnt_reg == '1) ? rd_cnt_reg : rd_cnt_reg + 32'd1;
        if (cmd.increment)
        begin
            wr_cnt_en = 1'b1;
        end
        else if (cmd.append && !table_full)
        begin
            wr_val_en = 1'b1;
            wr_cnt_en = 1'b1;
            wr_addr   = used_reg[AW-1:0];
            wr_cnt    = 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_val_en)
        begin
            val_mem[wr_addr] <= sample_reg;
        end
        if (wr_cnt_en)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        rd_val_reg <= val_mem[idx_reg[AW-1:0]];
        rd_cnt_reg <= cnt_mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            ovf_reg          <= 1'b0;
            idx_reg          <= '0;
            cmp_vld_reg      <= 1'b0;
            found_reg        <= 1'b0;
            bound_vld_reg    <= 1'b0;
            emitted_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
            if (cmd.load)
            begin
                bound_vld_reg <= 1'b0;
                emitted_reg   <= '0;
            end
            if (cmd.scan_clear)
            begin
                idx_reg     <= '0;
                cmp_vld_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            else if (cmd.scan_run && (idx_reg != used_reg))
            begin
                idx_reg     <= idx_reg + CW'(1);
                cmp_vld_reg <= 1'b1;
            end
            else
            begin
                cmp_vld_reg <= 1'b0;
            end
            if (cmd.rank && candidate && !cmd.scan_clear)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                bound_vld_reg <= 1'b1;
                emitted_reg   <= emitted_reg + CW'(1);
            end
            if (cmd.append)
            begin
                if (table_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    used_reg <= used_reg + CW'(1);
                end
            end
            if (cmd.finish)
            begin
                used_reg <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= item.sample_value;
        end
        if (cmd.scan_run)
        begin
            cmp_idx_reg <= idx_reg[AW-1:0];
        end
        if (cmd.rank && candidate)
        begin
            best_val_reg <= $signed(rd_val_reg);
            best_cnt_reg <= rd_cnt_reg;
        end
        if (cmd.emit)
        begin
            bound_reg               <= best_val_reg;
            result_reg.entry_value  <= best_val_reg;
            result_reg.entry_count  <= best_cnt_reg;
            result_reg.last_entry   <= sts.last;
            result_reg.dropped_flag <= ovf_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/distinct_value_frequency_counter.sv =====
// ----------------------------------------------------------------------------
// Distinct value frequency counter
// Counts occurrences of distinct signed values and reports them in
// descending value order on request, then empties the table.
// An add holds busy while one comparator steps through the stored entries
// of the value memory. A report holds busy for one scan of the stored
// entries per result, so results never come in consecutive cycles.
// Reset empties the table and clears the overflow flag at once; the
// memories themselves are not cleared, and results cannot be stalled.
// ----------------------------------------------------------------------------
module distinct_value_frequency_counter #(
    parameter int TABLE_ENTRIES = dvfc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dvfc_pkg::in_item_t   item,
    output logic                 busy,
    output logic                 result_valid,
    output dvfc_pkg::out_item_t  result
);

    dvfc_pkg::ctrl_cmd_t cmd;
    dvfc_pkg::ctrl_sts_t sts;

    dvfc_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item_cmd (item.cmd),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    dvfc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== rtl/dvfc_checker.sv =====
// ----------------------------------------------------------------------------
// Distinct value frequency counter checker
// Port-level checks on command and result sequencing.
// ----------------------------------------------------------------------------
`include "distinct_value_frequency_counter_macros.svh"

module dvfc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input dvfc_pkg::in_item_t   item,
    input logic                 busy,
    input logic                 result_valid,
    input dvfc_pkg::out_item_t  result
);

    `DVFC_ASSERT_NEXT(a_add_no_result, start && !busy && (item.cmd == dvfc_pkg::CMD_ADD), !result_valid)
    `DVFC_ASSERT_NOW(a_mid_result_busy, result_valid && !result.last_entry, busy)
    `DVFC_ASSERT_NOW(a_last_result_idle, result_valid && result.last_entry, !busy)
    `DVFC_ASSERT_NEXT(a_results_spaced, result_valid, !result_valid)

endmodule

bind distinct_value_frequency_counter dvfc_checker u_dvfc_checker (.*);

// ===== sim/distinct_value_frequency_counter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value frequency counter checker
// Watches the command and result channels of the frequency counter. It keeps
// its own table of distinct values and counts, expands every accepted report
// into the entries it must produce in descending value order, and compares
// each result transfer field by field with the oldest entry still owed.
// ----------------------------------------------------------------------------
module distinct_value_frequency_counter_checker #(
    parameter int TABLE_ENTRIES = dvfc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  dvfc_pkg::in_item_t  item,
    input  logic                busy,
    input  logic                result_valid,
    input  dvfc_pkg::out_item_t result,
    output int                  fail_count,
    output int                  pending
);

    logic signed [31:0]  tally_value [TABLE_ENTRIES];
    logic [31:0]         tally_count [TABLE_ENTRIES];
    int                  tally_used;
    logic                tally_dropped;
    dvfc_pkg::out_item_t owed_entries [$];
    dvfc_pkg::out_item_t oldest_entry;
    int                  mismatches;

    function automatic void count_sample(input logic signed [31:0] sample);
        int k;
        for (k = 0; k < tally_used; k++)
        begin
            if (tally_value[k] == sample)
            begin
                if (tally_count[k] != '1)
                    tally_count[k] += 32'd1;
                return;
            end
        end
        if (tally_used < TABLE_ENTRIES)
        begin
            tally_value[tally_used] = sample;
            tally_count[tally_used] = 32'd1;
            tally_used++;
        end
        else
            tally_dropped = 1'b1;
    endfunction

    function automatic void queue_ranked_entries();
        logic signed [31:0]  ranked_value [TABLE_ENTRIES];
        logic [31:0]         ranked_count [TABLE_ENTRIES];
        logic signed [31:0]  v;
        logic [31:0]         c;
        dvfc_pkg::out_item_t entry;
        int                  k;
        int                  j;
        for (k = 0; k < tally_used; k++)
        begin
            ranked_value[k] = tally_value[k];
            ranked_count[k] = tally_count[k];
        end
        for (k = 1; k < tally_used; k++)
        begin
            v = ranked_value[k];
            c = ranked_count[k];
            j = k;
            while (j > 0 && v > ranked_value[j - 1])
            begin
                ranked_value[j] = ranked_value[j - 1];
                ranked_count[j] = ranked_count[j - 1];
                j--;
            end
            ranked_value[j] = v;
            ranked_count[j] = c;
        end
        for (k = 0; k < tally_used; k++)
        begin
            entry.entry_value  = ranked_value[k];
            entry.entry_count  = ranked_count[k];
            entry.last_entry   = (k == tally_used - 1);
            entry.dropped_flag = tally_dropped;
            owed_entries.insert(owed_entries.size(), entry);
        end
        tally_used    = 0;
        tally_dropped = 1'b0;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] wanted,
                                          input logic [31:0] seen);
        if (seen !== wanted)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", field, wanted, seen);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_used    = 0;
            tally_dropped = 1'b0;
            owed_entries.delete();
            mismatches    = 0;
            fail_count    <= 0;
            pending       <= 0;
        end
        else
        begin
            if (result_valid === 1'b1)
            begin
                if (owed_entries.size() == 0)
                begin
                    $error("result transfer with no entry owed: entry_value 0x%08h",
                           result.entry_value);
                    mismatches++;
                end
                else
                begin
                    oldest_entry = owed_entries.pop_front();
                    compare_field("entry_value", oldest_entry.entry_value, result.entry_value);
                    compare_field("entry_count", oldest_entry.entry_count, result.entry_count);
                    compare_field("last_entry", oldest_entry.last_entry, result.last_entry);
                    compare_field("dropped_flag", oldest_entry.dropped_flag,
                                  result.dropped_flag);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                if (item.cmd == dvfc_pkg::CMD_ADD)
                    count_sample(item.sample_value);
                else
                    queue_ranked_entries();
            end
            fail_count <= mismatches;
            pending    <= owed_entries.size();
        end
    end

endmodule

// ===== sim/distinct_value_frequency_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value frequency counter testbench
// Drives add and report commands into the frequency counter: a directed
// opening with extreme values, repeats and empty reports, then runs of
// samples drawn from small pools and runs that fill the table past capacity,
// each closed by a report. The checker beside the block predicts and
// compares the reported entries; this module gives the verdict.
// ----------------------------------------------------------------------------
module distinct_value_frequency_counter_tb;

    localparam int TABLE_ENTRIES = dvfc_pkg::TABLE_ENTRIES_DEF;
    localparam int ITEM_TARGET   = 370;
    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 300;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    dvfc_pkg::in_item_t  item;
    logic                busy;
    logic                result_valid;
    dvfc_pkg::out_item_t result;
    int                  fail_count;
    int                  pending;
    int                  items_sent = 0;
    int                  quiet_cycles = 0;
    int                  episode;
    bit                  idle_enabled;

    always #5 clk = ~clk;

    distinct_value_frequency_counter #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .busy        (busy),
        .result_valid(result_valid),
        .result      (result)
    );

    distinct_value_frequency_counter_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .busy        (busy),
        .result_valid(result_valid),
        .result      (result),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || result_valid === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("distinct_value_frequency_counter: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFFFFFF;
                    1:       return 32'sh80000000;
                    2:       return 32'sh00000000;
                    default: return 32'shFFFFFFFF;
                endcase
            end
            1:       return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom();
        endcase
    endfunction

    task automatic transfer(input logic op, input logic signed [31:0] sample);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= dvfc_pkg::in_item_t'{op, sample};
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic fill_past_capacity();
        logic signed [31:0] pool [$];
        logic signed [31:0] candidate;
        int                 target;
        int                 k;
        int                 j;
        bit                 fresh;
        target = TABLE_ENTRIES + 1 + $urandom_range(0, 3);
        while (pool.size() < target)
        begin
            candidate = pick_value();
            fresh = 1'b1;
            for (k = 0; k < pool.size(); k++)
                if (pool[k] == candidate)
                    fresh = 1'b0;
            if (fresh)
                pool.insert(pool.size(), candidate);
        end
        for (k = pool.size() - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            candidate = pool[k];
            pool[k] = pool[j];
            pool[j] = candidate;
        end
        for (k = 0; k < pool.size(); k++)
        begin
            transfer(dvfc_pkg::CMD_ADD, pool[k]);
            if ($urandom_range(0, 3) == 0)
                transfer(dvfc_pkg::CMD_ADD, pool[$urandom_range(0, k)]);
        end
    endtask

    task automatic count_short_run();
        logic signed [31:0] pool [8];
        int                 pool_size;
        int                 adds;
        int                 k;
        pool_size = $urandom_range(1, 8);
        for (k = 0; k < pool_size; k++)
            pool[k] = pick_value();
        adds = $urandom_range(1, 20);
        for (k = 0; k < adds; k++)
        begin
            case ($urandom_range(0, 9))
                0:       transfer(dvfc_pkg::CMD_REPORT, $urandom());
                1:       transfer(dvfc_pkg::CMD_ADD, pick_value());
                default: transfer(dvfc_pkg::CMD_ADD, pool[$urandom_range(0, pool_size - 1)]);
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        idle_enabled = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        transfer(dvfc_pkg::CMD_REPORT, 32'sh00000000);
        transfer(dvfc_pkg::CMD_ADD, 32'sh7FFFFFFF);
        transfer(dvfc_pkg::CMD_ADD, 32'sh80000000);
        transfer(dvfc_pkg::CMD_ADD, 32'sh00000000);
        transfer(dvfc_pkg::CMD_ADD, 32'shFFFFFFFF);
        transfer(dvfc_pkg::CMD_ADD, 32'sh00000001);
        transfer(dvfc_pkg::CMD_ADD, 32'sh7FFFFFFF);
        transfer(dvfc_pkg::CMD_ADD, 32'sh55555555);
        transfer(dvfc_pkg::CMD_ADD, 32'shAAAAAAAA);
        transfer(dvfc_pkg::CMD_ADD, 32'sh80000000);
        transfer(dvfc_pkg::CMD_ADD, 32'shFFFFFFFF);
        transfer(dvfc_pkg::CMD_REPORT, 32'shFFFFFFFF);
        transfer(dvfc_pkg::CMD_REPORT, 32'sh55555555);
        transfer(dvfc_pkg::CMD_ADD, 32'shAAAAAAAA);
        transfer(dvfc_pkg::CMD_REPORT, 32'shAAAAAAAA);
        wait_for_results();

        episode = 0;
        while (items_sent < ITEM_TARGET)
        begin
            idle_enabled = (items_sent < ITEM_TARGET - 60) && ($urandom_range(0, 3) != 0);
            if (episode == 0 || episode == 6)
                fill_past_capacity();
            else
                count_short_run();
            transfer(dvfc_pkg::CMD_REPORT, $urandom());
            if (items_sent < ITEM_TARGET - 60 && $urandom_range(0, 3) == 0)
                wait_for_results();
            episode++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("distinct_value_frequency_counter: match");
        else
            $display("distinct_value_frequency_counter: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dvfc_pkg.sv
rtl/dvfc_controller.sv
rtl/dvfc_datapath.sv
rtl/distinct_value_frequency_counter.sv
rtl/dvfc_checker.sv
sim/distinct_value_frequency_counter_checker.sv
sim/distinct_value_frequency_counter_tb.sv
